// ===== rtl/urmw_pkg.sv =====
// shared types and constants for the unary read-modify-write alu
package urmw_pkg;

  // command codes
  typedef enum logic [3:0] {
    CMD_NEG = 4'd0,
    CMD_COM = 4'd1,
    CMD_LSR = 4'd2,
    CMD_ROR = 4'd3,
    CMD_ASR = 4'd4,
    CMD_LSL = 4'd5,
    CMD_ROL = 4'd6,
    CMD_DEC = 4'd7,
    CMD_INC = 4'd8,
    CMD_TST = 4'd9,
    CMD_CLR = 4'd10,
    CMD_DAA = 4'd11
  } cmd_t;

  // condition-code bit positions
  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_V = 1;
  localparam int unsigned FLAG_Z = 2;
  localparam int unsigned FLAG_N = 3;
  localparam int unsigned FLAG_H = 5;

  localparam logic [7:0] BYTE_MIN_NEG = 8'h80;
  localparam logic [7:0] BYTE_MAX_POS = 8'h7f;
  localparam logic [7:0] DAA_ADJ_LO   = 8'h06;
  localparam logic [7:0] DAA_ADJ_HI   = 8'h60;
  localparam logic [3:0] BCD_MAX      = 4'd9;
  localparam logic [3:0] BCD_HI_EDGE  = 4'd8;

endpackage

// ===== rtl/unary_read_modify_write_alu.sv =====
// top level: unary read-modify-write alu with decimal adjust
//
// 6809-style unary alu. each input word carries a command, one operand byte
// and the condition-code byte; each accepted word gives exactly one output
// word with the new byte, the new condition codes and a store flag (low for
// tst and for the unused command codes 12 to 15, which pass operand and
// flags through untouched). the block is a two-register pipeline: an input
// register, one level of byte/flag logic, and an output register. it takes
// one word every cycle as long as the output side keeps up. in_stall rises
// only when both registers hold words and the output side is stalling, so a
// finished word waiting at the output never blocks the next one from
// entering. bits of the condition codes that a command does not affect (h,
// i, f, e and the unaffected ones among n/z/v/c) pass through unchanged; v
// is left alone by daa. no state survives between words, and reset only
// clears the valids.
module unary_read_modify_write_alu (
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] command,
  input  logic [7:0] operand,
  input  logic [7:0] flags_in,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] result,
  output logic [7:0] flags_out,
  output logic       store
);

  // input register stage
  logic          s1_valid;
  urmw_pkg::cmd_t s1_cmd;
  logic [3:0]    s1_cmd_raw;
  logic [7:0]    s1_x;
  logic [7:0]    s1_cc;

  // pipeline advance controls
  logic adv_out;
  logic adv_in;

  // combinational results
  logic [7:0] result_next;
  logic [7:0] flags_next;
  logic       store_next;

  // output stage moves when empty or drained this cycle
  assign adv_out  = !out_valid || !out_stall;
  // input stage moves when empty or when it can hand over its word
  assign adv_in   = !s1_valid || adv_out;
  assign in_stall = !adv_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv_in) begin
      s1_valid <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (adv_in && in_valid) begin
      s1_cmd_raw <= command;
      s1_x       <= operand;
      s1_cc      <= flags_in;
    end
  end

  assign s1_cmd = urmw_pkg::cmd_t'(s1_cmd_raw);

  // byte and flag logic
  logic       oldc;
  logic [3:0] hi;
  logic [3:0] lo;
  logic [7:0] corr;
  logic [8:0] daa_sum;
  logic       nz_upd;

  always_comb begin
    oldc        = s1_cc[urmw_pkg::FLAG_C];
    hi          = s1_x[7:4];
    lo          = s1_x[3:0];
    corr        = 8'h00;
    daa_sum     = 9'd0;
    result_next = s1_x;
    flags_next  = s1_cc;
    store_next  = 1'b1;
    nz_upd      = 1'b1;

    unique case (s1_cmd)
      urmw_pkg::CMD_NEG: begin
        result_next = 8'h00 - s1_x;
        flags_next[urmw_pkg::FLAG_V] = (s1_x == urmw_pkg::BYTE_MIN_NEG);
        flags_next[urmw_pkg::FLAG_C] = (s1_x != 8'h00);
      end
      urmw_pkg::CMD_COM: begin
        result_next = ~s1_x;
        flags_next[urmw_pkg::FLAG_V] = 1'b0;
        flags_next[urmw_pkg::FLAG_C] = 1'b1;
      end
      urmw_pkg::CMD_LSR: begin
        result_next = {1'b0, s1_x[7:1]};
        flags_next[urmw_pkg::FLAG_C] = s1_x[0];
      end
      urmw_pkg::CMD_ROR: begin
        result_next = {oldc, s1_x[7:1]};
        flags_next[urmw_pkg::FLAG_C] = s1_x[0];
      end
      urmw_pkg::CMD_ASR: begin
        result_next = {s1_x[7], s1_x[7:1]};
        flags_next[urmw_pkg::FLAG_C] = s1_x[0];
      end
      urmw_pkg::CMD_LSL: begin
        result_next = {s1_x[6:0], 1'b0};
        flags_next[urmw_pkg::FLAG_C] = s1_x[7];
        flags_next[urmw_pkg::FLAG_V] = s1_x[7] ^ s1_x[6];
      end
      urmw_pkg::CMD_ROL: begin
        result_next = {s1_x[6:0], oldc};
        flags_next[urmw_pkg::FLAG_C] = s1_x[7];
        flags_next[urmw_pkg::FLAG_V] = s1_x[7] ^ s1_x[6];
      end
      urmw_pkg::CMD_DEC: begin
        result_next = s1_x - 8'd1;
        flags_next[urmw_pkg::FLAG_V] = (s1_x == urmw_pkg::BYTE_MIN_NEG);
      end
      urmw_pkg::CMD_INC: begin
        result_next = s1_x + 8'd1;
        flags_next[urmw_pkg::FLAG_V] = (s1_x == urmw_pkg::BYTE_MAX_POS);
      end
      urmw_pkg::CMD_TST: begin
        store_next = 1'b0;
        flags_next[urmw_pkg::FLAG_V] = 1'b0;
      end
      urmw_pkg::CMD_CLR: begin
        result_next = 8'h00;
        flags_next[urmw_pkg::FLAG_V] = 1'b0;
        flags_next[urmw_pkg::FLAG_C] = 1'b0;
      end
      urmw_pkg::CMD_DAA: begin
        // decimal adjust over the whole byte, carry is sticky
        if (s1_cc[urmw_pkg::FLAG_H] || (lo > urmw_pkg::BCD_MAX)) begin
          corr = corr | urmw_pkg::DAA_ADJ_LO;
        end
        if (oldc || (hi > urmw_pkg::BCD_MAX) ||
            ((hi > urmw_pkg::BCD_HI_EDGE) && (lo > urmw_pkg::BCD_MAX))) begin
          corr = corr | urmw_pkg::DAA_ADJ_HI;
        end
        daa_sum     = {1'b0, s1_x} + {1'b0, corr};
        result_next = daa_sum[7:0];
        flags_next[urmw_pkg::FLAG_C] = oldc | daa_sum[8];
      end
      default: begin
        // unused codes pass everything through
        store_next = 1'b0;
        nz_upd     = 1'b0;
      end
    endcase

    if (nz_upd) begin
      flags_next[urmw_pkg::FLAG_N] = result_next[7];
      flags_next[urmw_pkg::FLAG_Z] = (result_next == 8'h00);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_out) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && s1_valid) begin
      result    <= result_next;
      flags_out <= flags_next;
      store     <= store_next;
    end
  end

  // the input side only stalls when both stages are full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("in_stall with a free pipeline slot");

  // a word in the input stage that moves on shows up at the output
  a_handover: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && adv_out) |=> out_valid)
    else $error("word lost between stages");

  // tst never writes back and leaves the byte alone
  a_tst_nostore: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && adv_out && (s1_cmd == urmw_pkg::CMD_TST)) |=>
      (!store && (result == $past(s1_x))))
    else $error("tst result wrong");

  // clr gives zero with z set and n, v, c clear
  a_clr: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && adv_out && (s1_cmd == urmw_pkg::CMD_CLR)) |=>
      ((result == 8'h00) && store && (flags_out[3:0] == 4'b0100)))
    else $error("clr result wrong");

endmodule

// ===== sim/unary_read_modify_write_alu_test.sv =====
// self-checking testbench for the unary read-modify-write alu
module unary_read_modify_write_alu_test;

  // command codes past daa carry no operation: byte and flags pass through
  localparam logic [3:0] CMD_SPARE_LO = 4'd12;
  localparam logic [3:0] CMD_SPARE_HI = 4'd15;

  // generous cycle budget: ~1950 words, each allowed long sender gaps and
  // long solid output stalls, taken several times over
  localparam int CYCLE_LIMIT  = 400000;
  // pipeline is two registers deep; a few extra cycles catch stray words
  localparam int SETTLE_CYCLES = 8;

  // how the output side stalls during one stretch
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_SOLID
  } stall_mode_t;

  // one output word: new byte, new condition codes, write-back flag
  typedef struct packed {
    logic [7:0] result;
    logic [7:0] flags;
    logic       store;
  } rmw_word_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [3:0] command;
  logic [7:0] operand;
  logic [7:0] flags_in;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] result;
  logic [7:0] flags_out;
  logic       store;

  // words predicted at acceptance, oldest first
  rmw_word_t   expected_words[$];
  int          words_sent;
  int          words_checked;
  int          mismatches;
  int          bcd_adjusts;
  int          cmd_hits[16];
  int          cycle_count;
  // sender burst bookkeeping
  int          burst_left;
  // receiver stall pattern
  stall_mode_t stall_mode;
  int          stall_left;

  unary_read_modify_write_alu dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .operand   (operand),
    .flags_in  (flags_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result),
    .flags_out (flags_out),
    .store     (store)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // predictor: new byte and condition codes for one command
  // bits a command does not touch (h, i, f, e and the rest) carry through
  // ---------------------------------------------------------------------
  function automatic rmw_word_t rmw_predict(logic [3:0] cmd, logic [7:0] x,
                                            logic [7:0] cc);
    rmw_word_t  w;
    logic       old_c;
    logic       sets_nz;
    logic [7:0] corr;
    logic [8:0] sum;
    w.result = x;
    w.store  = 1'b1;
    old_c    = cc[urmw_pkg::FLAG_C];
    sets_nz  = 1'b1;
    corr     = 8'h00;
    sum      = 9'h000;
    case (cmd)
      urmw_pkg::CMD_NEG: begin
        w.result  = 8'h00 - x;
        cc[urmw_pkg::FLAG_V] = (x == urmw_pkg::BYTE_MIN_NEG);
        cc[urmw_pkg::FLAG_C] = (x != 8'h00);
      end
      urmw_pkg::CMD_COM: begin
        w.result  = ~x;
        cc[urmw_pkg::FLAG_V] = 1'b0;
        cc[urmw_pkg::FLAG_C] = 1'b1;
      end
      urmw_pkg::CMD_LSR: begin
        // n always ends up clear since bit 7 of the result is zero
        w.result  = {1'b0, x[7:1]};
        cc[urmw_pkg::FLAG_C] = x[0];
      end
      urmw_pkg::CMD_ROR: begin
        w.result  = {old_c, x[7:1]};
        cc[urmw_pkg::FLAG_C] = x[0];
      end
      urmw_pkg::CMD_ASR: begin
        w.result  = {x[7], x[7:1]};
        cc[urmw_pkg::FLAG_C] = x[0];
      end
      urmw_pkg::CMD_LSL, urmw_pkg::CMD_ROL: begin
        w.result  = {x[6:0], (cmd == urmw_pkg::CMD_ROL) ? old_c : 1'b0};
        cc[urmw_pkg::FLAG_C] = x[7];
        cc[urmw_pkg::FLAG_V] = x[7] ^ x[6];
      end
      urmw_pkg::CMD_DEC: begin
        w.result  = x - 8'h01;
        cc[urmw_pkg::FLAG_V] = (x == urmw_pkg::BYTE_MIN_NEG);
      end
      urmw_pkg::CMD_INC: begin
        w.result  = x + 8'h01;
        cc[urmw_pkg::FLAG_V] = (x == urmw_pkg::BYTE_MAX_POS);
      end
      urmw_pkg::CMD_TST: begin
        w.store   = 1'b0;
        cc[urmw_pkg::FLAG_V] = 1'b0;
      end
      urmw_pkg::CMD_CLR: begin
        w.result  = 8'h00;
        cc[urmw_pkg::FLAG_V] = 1'b0;
        cc[urmw_pkg::FLAG_C] = 1'b0;
      end
      urmw_pkg::CMD_DAA: begin
        // corrections go over the whole byte; carry is sticky; v untouched
        if (cc[urmw_pkg::FLAG_H] || x[3:0] > urmw_pkg::BCD_MAX)
          corr = corr | urmw_pkg::DAA_ADJ_LO;
        if (old_c || x[7:4] > urmw_pkg::BCD_MAX ||
            (x[7:4] > urmw_pkg::BCD_HI_EDGE && x[3:0] > urmw_pkg::BCD_MAX))
          corr = corr | urmw_pkg::DAA_ADJ_HI;
        sum       = {1'b0, x} + {1'b0, corr};
        w.result  = sum[7:0];
        cc[urmw_pkg::FLAG_C] = old_c | sum[8];
      end
      default: begin
        // spare codes: no write-back, nothing changes
        w.store = 1'b0;
        sets_nz = 1'b0;
      end
    endcase
    if (sets_nz) begin
      cc[urmw_pkg::FLAG_N] = w.result[7];
      cc[urmw_pkg::FLAG_Z] = (w.result == 8'h00);
    end
    w.flags = cc;
    return w;
  endfunction

  // ---------------------------------------------------------------------
  // sender: present one word, hold it until accepted, then maybe idle
  // ---------------------------------------------------------------------
  task automatic send_word(input logic [3:0] cmd, input logic [7:0] x,
                           input logic [7:0] cc);
    int gap;
    in_valid <= 1'b1;
    command  <= cmd;
    operand  <= x;
    flags_in <= cc;
    // accepted at the edge where valid is high and stall was low
    do @(posedge clk); while (in_stall);
    expected_words.push_back(rmw_predict(cmd, x, cc));
    words_sent++;
    cmd_hits[cmd]++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // end of burst: drop valid for a while, then pick the next burst
      in_valid <= 1'b0;
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  // hold valid low until every predicted word has come out
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // receiver: stall in stretches of random mode and length
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(5, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 1) == 0);
      default:     out_stall <= 1'b1;
    endcase
  end

  // ---------------------------------------------------------------------
  // checker: every accepted output word against the oldest prediction
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    rmw_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word result=%02h flags=%02h store=%0b",
                 $time, result, flags_out, store);
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (result !== want.result) begin
          $display("%0t: result expected %02h actual %02h", $time, want.result, result);
          mismatches++;
        end
        if (flags_out !== want.flags) begin
          $display("%0t: flags expected %02h actual %02h", $time, want.flags, flags_out);
          mismatches++;
        end
        if (store !== want.store) begin
          $display("%0t: store expected %0b actual %0b", $time, want.store, store);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_count, expected_words.size());
      $display("unary_read_modify_write_alu_test NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // corner cases of every command, plus the spare codes
  task automatic test_directed_edges();
    logic [7:0] h_and_c;
    h_and_c = (8'h01 << urmw_pkg::FLAG_H) | (8'h01 << urmw_pkg::FLAG_C);
    // overflow on the most negative byte
    send_word(urmw_pkg::CMD_NEG, urmw_pkg::BYTE_MIN_NEG, 8'h00);
    send_word(urmw_pkg::CMD_NEG, 8'h00, 8'hff);          // zero: no borrow
    send_word(urmw_pkg::CMD_COM, 8'h00, 8'h00);
    send_word(urmw_pkg::CMD_COM, 8'hff, 8'hff);
    send_word(urmw_pkg::CMD_LSR, 8'h01, 8'hff);          // shifts to zero, carry out
    send_word(urmw_pkg::CMD_ROR, 8'h01, 8'h01);          // old carry into bit 7
    send_word(urmw_pkg::CMD_ASR, 8'h81, 8'h00);          // sign bit kept
    send_word(urmw_pkg::CMD_LSL, 8'hc0, 8'h00);
    send_word(urmw_pkg::CMD_LSL, 8'h40, 8'hff);          // v from bit 7 xor bit 6
    send_word(urmw_pkg::CMD_ROL, 8'h80, 8'h01);
    send_word(urmw_pkg::CMD_DEC, urmw_pkg::BYTE_MIN_NEG, 8'h00);
    send_word(urmw_pkg::CMD_DEC, 8'h00, 8'hff);          // wraps, carry left alone
    send_word(urmw_pkg::CMD_INC, urmw_pkg::BYTE_MAX_POS, 8'h00);
    send_word(urmw_pkg::CMD_INC, 8'hff, 8'hff);
    send_word(urmw_pkg::CMD_TST, 8'h00, 8'hff);          // no write-back
    send_word(urmw_pkg::CMD_TST, 8'h80, 8'h02);
    send_word(urmw_pkg::CMD_CLR, 8'hff, 8'hff);
    // high nibble 9 with low nibble over 9
    send_word(urmw_pkg::CMD_DAA, 8'h9a, 8'h00);
    send_word(urmw_pkg::CMD_DAA, 8'h00, h_and_c);        // both corrections from h and c
    send_word(urmw_pkg::CMD_DAA, 8'hff, 8'h02);          // v must survive daa
    send_word(urmw_pkg::CMD_DAA, 8'h99, 8'h00);          // already valid bcd
    send_word(CMD_SPARE_LO, 8'h5a, 8'ha5);
    send_word(CMD_SPARE_HI, 8'hff, 8'hff);
  endtask

  // any command code, any operand, any condition-code byte
  task automatic test_random_commands(input int count);
    for (int i = 0; i < count; i++)
      send_word(4'($urandom_range(0, 15)), 8'($urandom), 8'($urandom));
  endtask

  // rounds of random traffic, each followed by a full drain of the pipeline
  task automatic test_drain_pauses(input int rounds, input int per_round);
    for (int r = 0; r < rounds; r++) begin
      test_random_commands(per_round);
      wait_for_drain();
    end
  endtask

  // daa after a real bcd addition: h and c as the add would leave them,
  // with some plain noise mixed in
  task automatic test_bcd_adjust(input int count);
    int         a;
    int         b;
    int         cin;
    int         lo_sum;
    int         full_sum;
    logic [7:0] a_bcd;
    logic [7:0] b_bcd;
    logic [7:0] cc;
    for (int i = 0; i < count; i++) begin
      cc = 8'($urandom);
      if ($urandom_range(0, 9) == 0) begin
        send_word(urmw_pkg::CMD_DAA, 8'($urandom), cc);
      end else begin
        a        = $urandom_range(0, 99);
        b        = $urandom_range(0, 99);
        cin      = $urandom_range(0, 1);
        a_bcd    = {4'(a / 10), 4'(a % 10)};
        b_bcd    = {4'(b / 10), 4'(b % 10)};
        lo_sum   = a_bcd[3:0] + b_bcd[3:0] + cin;
        full_sum = a_bcd + b_bcd + cin;
        cc[urmw_pkg::FLAG_H] = (lo_sum > 15);
        cc[urmw_pkg::FLAG_C] = (full_sum > 255);
        send_word(urmw_pkg::CMD_DAA, 8'(full_sum), cc);
        bcd_adjusts++;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    int kinds;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    command    <= urmw_pkg::CMD_NEG;
    operand    <= 8'h00;
    flags_in   <= 8'h00;
    out_stall  <= 1'b0;
    stall_mode <= STALL_NONE;
    stall_left <= 0;
    burst_left  = 0;
    words_sent    = 0;
    words_checked = 0;
    mismatches    = 0;
    bcd_adjusts   = 0;
    cycle_count   = 0;
    kinds         = 0;
    foreach (cmd_hits[i]) cmd_hits[i] = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed_edges();
    test_random_commands(1150);
    test_drain_pauses(3, 120);
    test_bcd_adjust(420);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    foreach (cmd_hits[i]) if (cmd_hits[i] != 0) kinds++;
    $display("sent %0d words over %0d command codes, checked %0d results",
             words_sent, kinds, words_checked);
    $display("%0d decimal adjusts followed a bcd addition, %0d field mismatches",
             bcd_adjusts, mismatches);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("unary_read_modify_write_alu_test OK");
    end else begin
      $display("unary_read_modify_write_alu_test NOT OK");
    end
    $finish;
  end

endmodule
